[sv/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/tmfc_pkg.sv]
// ----------------------------------------------------------------------------
// tmfc_pkg
// Constants, codes and shared types of the tab message frame checker.
// ----------------------------------------------------------------------------
package tmfc_pkg;

  localparam int LINE_MAX   = 256;
  localparam int TOKENS_MAX = 8;
  localparam int TOKEN_MAX  = 16;
  localparam int TYPE_MAX   = 8;

  localparam int LINE_W   = $clog2(LINE_MAX);
  localparam int TOK_W    = $clog2(TOKENS_MAX + 1);
  // Character position only matters below the larger of the two cut lengths.
  localparam int CHAR_LIM = ((TOKEN_MAX > TYPE_MAX) ? TOKEN_MAX : TYPE_MAX) - 1;
  localparam int CHAR_W   = $clog2(CHAR_LIM + 1);
  localparam int TLEN_W   = $clog2(TYPE_MAX);

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FAIL     = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN  = 2'd3;

  localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
  localparam logic [1:0] TYPE_PING    = 2'd1;
  localparam logic [1:0] TYPE_POS     = 2'd2;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       eom;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic        mismatch;
    logic [1:0]  status;
    logic [1:0]  msg_type;
    logic [2:0]  fields;
    logic [15:0] expected;
    logic [15:0] computed;
  } summary_t;

  function automatic logic [7:0] ping_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h50; // P
      2'd1:    ch = 8'h49; // I
      2'd2:    ch = 8'h4E; // N
      default: ch = 8'h47; // G
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] pos_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h50; // P
      2'd1:    ch = 8'h4F; // O
      default: ch = 8'h53; // S
    endcase
    return ch;
  endfunction

endpackage

[sv/tmfc_in_stage.sv]
// ----------------------------------------------------------------------------
// tmfc_in_stage
// Input register for one message byte; releases it to the parser, a closing
// byte only when the result register can take its result.
// ----------------------------------------------------------------------------
module tmfc_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      msg_byte_i,
  input  logic            end_of_message_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            res_free_i,
  output logic            fire_o,
  output tmfc_pkg::item_t item_o
);
  import tmfc_pkg::*;

  logic  valid_q;
  item_t item_q;

  // Only a closing byte needs room in the result register.
  assign fire_o     = valid_q && (!item_q.eom || res_free_i);
  assign in_ready_o = !valid_q || fire_o;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.msg_byte <= msg_byte_i;
      item_q.eom      <= end_of_message_i;
    end
  end

endmodule

[sv/tmfc_parser.sv]
// ----------------------------------------------------------------------------
// tmfc_parser
// Per-message tokenizer state: byte sum, tab snapshot, token counting, type
// matching and checksum digit parsing, with the summary of a closing byte.
// ----------------------------------------------------------------------------
module tmfc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  tmfc_pkg::item_t    item_i,
  output tmfc_pkg::summary_t summary_o
);
  import tmfc_pkg::*;

  logic [15:0]       run_q, run_d;
  logic [15:0]       last_tab_q, last_tab_d;
  logic              tab_seen_q, tab_seen_d;
  logic [LINE_W-1:0] bytes_q, bytes_d;
  logic [TOK_W-1:0]  tokens_q, tokens_d;
  logic              inside_q, inside_d;
  logic [CHAR_W-1:0] chars_q, chars_d;
  logic [1:0]        tms_q, tms_d;
  logic [TLEN_W-1:0] tlen_q, tlen_d;
  logic              space_q, space_d;
  logic              dend_q, dend_d;
  logic              cas_q, cas_d;
  logic [15:0]       psum_q, psum_d;

  logic [7:0]        c;
  logic              is_tab;
  logic              is_digit;
  logic [CHAR_W-1:0] p;
  logic [TOK_W-1:0]  captured;
  logic [1:0]        msg_type;
  logic              ok;
  logic              mismatch;

  assign c        = item_i.msg_byte;
  assign is_tab   = (c == CHAR_TAB);
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

  always_comb begin
    run_d      = run_q + {8'h00, c};
    last_tab_d = last_tab_q;
    tab_seen_d = tab_seen_q;
    bytes_d    = bytes_q;
    tokens_d   = tokens_q;
    inside_d   = inside_q;
    chars_d    = chars_q;
    tms_d      = tms_q;
    tlen_d     = tlen_q;
    space_d    = space_q;
    dend_d     = dend_q;
    cas_d      = cas_q;
    psum_d     = psum_q;
    p          = chars_q;

    if (is_tab) begin
      last_tab_d = run_q;
      tab_seen_d = 1'b1;
    end

    // Bytes past the line limit only feed the byte sum and the tab snapshot.
    if (int'(bytes_q) < LINE_MAX - 1) begin
      bytes_d = bytes_q + LINE_W'(1);
      if (is_tab) begin
        inside_d = 1'b0;
      end else begin
        if (!inside_q) begin
          inside_d = 1'b1;
          if (int'(tokens_q) < TOKENS_MAX) begin
            tokens_d = tokens_q + TOK_W'(1);
          end
          chars_d = '0;
          space_d = 1'b0;
          dend_d  = 1'b0;
          cas_d   = 1'b0;
          psum_d  = '0;
        end
        p = chars_d;
        if (int'(tokens_d) <= TOKENS_MAX - 1) begin
          if (int'(tokens_d) == 1 && int'(p) < TYPE_MAX - 1) begin
            tlen_d = TLEN_W'(int'(p) + 1);
            if (int'(p) >= 4 || c != ping_char(p[1:0])) begin
              tms_d[0] = 1'b1;
            end
            if (int'(p) >= 3 || c != pos_char(p[1:0])) begin
              tms_d[1] = 1'b1;
            end
          end
          if (int'(p) < TOKEN_MAX - 1) begin
            if (!space_d) begin
              if (c == CHAR_SPACE) begin
                space_d = 1'b1;
              end
            end else begin
              cas_d = 1'b1;
              if (!dend_d) begin
                if (is_digit) begin
                  psum_d = (psum_d << 3) + (psum_d << 1) + {8'h00, c - CHAR_ZERO};
                end else begin
                  dend_d = 1'b1;
                end
              end
            end
          end
          if (int'(p) < CHAR_LIM) begin
            chars_d = p + CHAR_W'(1);
          end
        end
      end
    end
  end

  // Summary as seen after the closing byte has been taken in.
  always_comb begin
    if (int'(tokens_d) > TOKENS_MAX - 1) begin
      captured = TOK_W'(TOKENS_MAX - 1);
    end else begin
      captured = tokens_d;
    end
    ok       = (int'(captured) >= 2) && space_d && cas_d && tab_seen_d;
    mismatch = (psum_d != last_tab_d);
    if (!tms_d[0] && int'(tlen_d) == 4) begin
      msg_type = TYPE_PING;
    end else if (!tms_d[1] && int'(tlen_d) == 3) begin
      msg_type = TYPE_POS;
    end else begin
      msg_type = TYPE_UNKNOWN;
    end

    summary_o.ok       = ok;
    summary_o.mismatch = ok && mismatch;
    if (!ok) begin
      summary_o.status   = STATUS_FAIL;
      summary_o.msg_type = TYPE_UNKNOWN;
      summary_o.fields   = '0;
      summary_o.expected = '0;
      summary_o.computed = '0;
    end else begin
      if (mismatch) begin
        summary_o.status = STATUS_MISMATCH;
      end else if (msg_type != TYPE_UNKNOWN) begin
        summary_o.status = STATUS_OK;
      end else begin
        summary_o.status = STATUS_UNKNOWN;
      end
      summary_o.msg_type = msg_type;
      summary_o.fields   = 3'(int'(captured) - 2);
      summary_o.expected = psum_d;
      summary_o.computed = last_tab_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= '0;
      last_tab_q <= '0;
      tab_seen_q <= 1'b0;
      bytes_q    <= '0;
      tokens_q   <= '0;
      inside_q   <= 1'b0;
      chars_q    <= '0;
      tms_q      <= '0;
      tlen_q     <= '0;
      space_q    <= 1'b0;
      dend_q     <= 1'b0;
      cas_q      <= 1'b0;
      psum_q     <= '0;
    end else if (fire_i) begin
      if (item_i.eom) begin
        // The message is closed: everything per message starts again.
        run_q      <= '0;
        last_tab_q <= '0;
        tab_seen_q <= 1'b0;
        bytes_q    <= '0;
        tokens_q   <= '0;
        inside_q   <= 1'b0;
        chars_q    <= '0;
        tms_q      <= '0;
        tlen_q     <= '0;
        space_q    <= 1'b0;
        dend_q     <= 1'b0;
        cas_q      <= 1'b0;
        psum_q     <= '0;
      end else begin
        run_q      <= run_d;
        last_tab_q <= last_tab_d;
        tab_seen_q <= tab_seen_d;
        bytes_q    <= bytes_d;
        tokens_q   <= tokens_d;
        inside_q   <= inside_d;
        chars_q    <= chars_d;
        tms_q      <= tms_d;
        tlen_q     <= tlen_d;
        space_q    <= space_d;
        dend_q     <= dend_d;
        cas_q      <= cas_d;
        psum_q     <= psum_d;
      end
    end
  end

endmodule

[sv/tmfc_result.sv]
// ----------------------------------------------------------------------------
// tmfc_result
// Result register and the wrapping statistics counters.
// ----------------------------------------------------------------------------
module tmfc_result (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tmfc_pkg::summary_t summary_i,
  output logic               res_free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [1:0]         msg_type_o,
  output logic [2:0]         field_count_o,
  output logic [15:0]        expected_sum_o,
  output logic [15:0]        computed_sum_o,
  output logic [31:0]        good_parse_count_o,
  output logic [31:0]        bad_parse_count_o,
  output logic [31:0]        sum_error_count_o
);
  import tmfc_pkg::*;

  logic        valid_q;
  summary_t    res_q;
  logic [31:0] good_q, bad_q, err_q;

  assign res_free_o = !valid_q || out_ready_i;

  // Counters only move on a load, and a load waits for the slot to free, so
  // they always show the values after the message on display.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      good_q  <= '0;
      bad_q   <= '0;
      err_q   <= '0;
    end else begin
      if (load_i) begin
        valid_q <= 1'b1;
        good_q  <= good_q + {31'd0, summary_i.ok};
        bad_q   <= bad_q + {31'd0, !summary_i.ok};
        err_q   <= err_q + {31'd0, summary_i.mismatch};
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= summary_i;
    end
  end

  assign out_valid_o        = valid_q;
  assign status_o           = res_q.status;
  assign msg_type_o         = res_q.msg_type;
  assign field_count_o      = res_q.fields;
  assign expected_sum_o     = res_q.expected;
  assign computed_sum_o     = res_q.computed;
  assign good_parse_count_o = good_q;
  assign bad_parse_count_o  = bad_q;
  assign sum_error_count_o  = err_q;

endmodule

[sv/tab_message_frame_checker.sv]
// A result passes through the input register and then the result register before it is shown.
// Throughput: one byte per cycle, except while a closing byte waits for the result register.
// A closing byte waits in the input register only while an earlier result is untaken.
// Reset (asynchronous, active low) clears all message state and the three counters.
// ----------------------------------------------------------------------------
// tab_message_frame_checker
// Checks tab-separated messages byte by byte: type, field count and checksum.
// ----------------------------------------------------------------------------
module tab_message_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  msg_byte_i,
  input  logic        end_of_message_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [1:0]  status_o,
  output logic [1:0]  msg_type_o,
  output logic [2:0]  field_count_o,
  output logic [15:0] expected_sum_o,
  output logic [15:0] computed_sum_o,
  output logic [31:0] good_parse_count_o,
  output logic [31:0] bad_parse_count_o,
  output logic [31:0] sum_error_count_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  import tmfc_pkg::*;

  logic     res_free;
  logic     fire;
  item_t    item;
  summary_t summary;

  tmfc_in_stage u_in_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .msg_byte_i      (msg_byte_i),
    .end_of_message_i(end_of_message_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .res_free_i      (res_free),
    .fire_o          (fire),
    .item_o          (item)
  );

  tmfc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .summary_o(summary)
  );

  tmfc_result u_result (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (fire && item.eom),
    .summary_i         (summary),
    .res_free_o        (res_free),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .msg_type_o        (msg_type_o),
    .field_count_o     (field_count_o),
    .expected_sum_o    (expected_sum_o),
    .computed_sum_o    (computed_sum_o),
    .good_parse_count_o(good_parse_count_o),
    .bad_parse_count_o (bad_parse_count_o),
    .sum_error_count_o (sum_error_count_o)
  );

endmodule

[sv/tmfc_checker.sv]
// ----------------------------------------------------------------------------
// tmfc_checker
// Port-level checks of the frame checker, attached by a bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [1:0]  status_o,
  input logic [1:0]  msg_type_o,
  input logic [2:0]  field_count_o,
  input logic [15:0] expected_sum_o,
  input logic [15:0] computed_sum_o,
  input logic [31:0] sum_error_count_o,
  input logic        out_valid_o,
  input logic        out_ready_i
);
  import tmfc_pkg::*;

  // A waiting result keeps its status, expected sum and error count.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(expected_sum_o) && $stable(sum_error_count_o))

  // A parse failure reports no type, fields or sums.
  `ASSERT_IMPLIES(a_fail_zero, clk_i, rst_ni, out_valid_o && status_o == STATUS_FAIL, msg_type_o == TYPE_UNKNOWN && field_count_o == 3'd0 && expected_sum_o == 16'd0 && computed_sum_o == 16'd0)

  // OK needs a known type and matching sums.
  `ASSERT_IMPLIES(a_ok_match, clk_i, rst_ni, out_valid_o && status_o == STATUS_OK, msg_type_o != TYPE_UNKNOWN && expected_sum_o == computed_sum_o)

  // A mismatch really has differing sums, and so does nothing else.
  `ASSERT_IMPLIES(a_mismatch, clk_i, rst_ni, out_valid_o && status_o != STATUS_FAIL, (status_o == STATUS_MISMATCH) == (expected_sum_o != computed_sum_o))

endmodule

bind tab_message_frame_checker tmfc_checker u_tmfc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .status_o         (status_o),
  .msg_type_o       (msg_type_o),
  .field_count_o    (field_count_o),
  .expected_sum_o   (expected_sum_o),
  .computed_sum_o   (computed_sum_o),
  .sum_error_count_o(sum_error_count_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i)
);

[test/tab_message_frame_checker_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tab_message_frame_checker_test
// Streams tab-separated messages into the frame checker one byte per
// transaction and compares each reported status, type, field count, checksum
// pair and statistics counter with a behavioural parser kept in this bench.
// ----------------------------------------------------------------------------
module tab_message_frame_checker_test;
  import tmfc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  msg_type;
    logic [2:0]  field_count;
    logic [15:0] expected_sum;
    logic [15:0] computed_sum;
    logic [31:0] good_count;
    logic [31:0] bad_count;
    logic [31:0] sum_err_count;
  } frame_result_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic [7:0]  msg_byte_i       = 8'h00;
  logic        end_of_message_i = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  status_o;
  logic [1:0]  msg_type_o;
  logic [2:0]  field_count_o;
  logic [15:0] expected_sum_o;
  logic [15:0] computed_sum_o;
  logic [31:0] good_parse_count_o;
  logic [31:0] bad_parse_count_o;
  logic [31:0] sum_error_count_o;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;

  // Parser state, mirroring what the block keeps per message.
  logic [15:0] run_sum      = '0;
  logic [15:0] tab_snapshot = '0;
  logic [15:0] digit_value  = '0;
  bit          tab_found, in_token, space_found, digits_done, text_after_space;
  int unsigned line_bytes, token_total, token_pos, type_chars;
  logic [1:0]  type_rejected = '0;
  logic [31:0] good_total    = '0;
  logic [31:0] bad_total     = '0;
  logic [31:0] sum_err_total = '0;
  string       ping_word     = "PING";
  string       pos_word      = "POS";

  frame_result_t pending_results[$];
  logic [7:0]    frame_bytes[$];

  int send_idle_pct   = 32;
  int recv_idle_pct   = 47;
  int hold_off_cycles = 0;
  int error_count     = 0;
  int quiet_cycles    = 0;

  tab_message_frame_checker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .msg_byte_i         (msg_byte_i),
    .end_of_message_i   (end_of_message_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .status_o           (status_o),
    .msg_type_o         (msg_type_o),
    .field_count_o      (field_count_o),
    .expected_sum_o     (expected_sum_o),
    .computed_sum_o     (computed_sum_o),
    .good_parse_count_o (good_parse_count_o),
    .bad_parse_count_o  (bad_parse_count_o),
    .sum_error_count_o  (sum_error_count_o),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_frame_state();
    run_sum          = '0;
    tab_snapshot     = '0;
    digit_value      = '0;
    tab_found        = 1'b0;
    in_token         = 1'b0;
    space_found      = 1'b0;
    digits_done      = 1'b0;
    text_after_space = 1'b0;
    line_bytes       = 0;
    token_total      = 0;
    token_pos        = 0;
    type_chars       = 0;
    type_rejected    = '0;
  endfunction

  // Advances the parser by one byte; returns 1 when the byte closes a message.
  function automatic bit parse_byte(input logic [7:0] c, input bit last,
                                    output frame_result_t r);
    int unsigned p;
    int unsigned captured;
    r = '0;
    if (c == CHAR_TAB) begin
      tab_snapshot = run_sum;
      tab_found    = 1'b1;
    end
    run_sum = run_sum + 16'(c);
    // Bytes past the line limit only feed the sum and the last-tab snapshot.
    if (line_bytes < LINE_MAX - 1) begin
      line_bytes++;
      if (c == CHAR_TAB) begin
        in_token = 1'b0;
      end else begin
        if (!in_token) begin
          in_token = 1'b1;
          if (token_total < TOKENS_MAX) token_total++;
          token_pos        = 0;
          space_found      = 1'b0;
          digits_done      = 1'b0;
          text_after_space = 1'b0;
          digit_value      = '0;
        end
        if (token_total <= TOKENS_MAX - 1) begin
          p = token_pos;
          if (token_total == 1 && p < TYPE_MAX - 1) begin
            type_chars = p + 1;
            if (p >= 4 || c != ping_word[p]) type_rejected[0] = 1'b1;
            if (p >= 3 || c != pos_word[p]) type_rejected[1] = 1'b1;
          end
          if (p < TOKEN_MAX - 1) begin
            if (!space_found) begin
              if (c == CHAR_SPACE) space_found = 1'b1;
            end else begin
              text_after_space = 1'b1;
              if (!digits_done) begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                  digit_value = digit_value * 16'd10 + 16'(c - CHAR_ZERO);
                else
                  digits_done = 1'b1;
              end
            end
          end
          if (token_pos < 127) token_pos++;
        end
      end
    end
    if (!last) return 1'b0;

    captured = (token_total > TOKENS_MAX - 1) ? TOKENS_MAX - 1 : token_total;
    if (captured >= 2 && space_found && text_after_space && tab_found) begin
      good_total++;
      r.field_count  = 3'(captured - 2);
      r.expected_sum = digit_value;
      r.computed_sum = tab_snapshot;
      if (!type_rejected[0] && type_chars == 4)
        r.msg_type = TYPE_PING;
      else if (!type_rejected[1] && type_chars == 3)
        r.msg_type = TYPE_POS;
      else
        r.msg_type = TYPE_UNKNOWN;
      if (digit_value != tab_snapshot) begin
        sum_err_total++;
        r.status = STATUS_MISMATCH;
      end else begin
        r.status = (r.msg_type != TYPE_UNKNOWN) ? STATUS_OK : STATUS_UNKNOWN;
      end
    end else begin
      bad_total++;
      r.status = STATUS_FAIL;
    end
    r.good_count    = good_total;
    r.bad_count     = bad_total;
    r.sum_err_count = sum_err_total;
    clear_frame_state();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Result checker: every accepted result is matched against the oldest one due.
  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("status", status_o, want.status);
        check_field("msg_type", msg_type_o, want.msg_type);
        check_field("field_count", field_count_o, want.field_count);
        check_field("expected_sum", expected_sum_o, want.expected_sum);
        check_field("computed_sum", computed_sum_o, want.computed_sum);
        check_field("good_parse_count", good_parse_count_o, want.good_count);
        check_field("bad_parse_count", bad_parse_count_o, want.bad_count);
        check_field("sum_error_count", sum_error_count_o, want.sum_err_count);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one has been requested.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_off_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Entered and left just after a falling edge.
  task automatic send_byte(input logic [7:0] b, input bit last);
    frame_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    msg_byte_i       <= b;
    end_of_message_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (parse_byte(b, last, r)) pending_results.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  function automatic logic [15:0] frame_sum();
    logic [15:0] s = '0;
    foreach (frame_bytes[i]) s += 16'(frame_bytes[i]);
    return s;
  endfunction

  function automatic logic [7:0] random_text_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0: c = 8'($urandom_range(8'h61, 8'h7a));
      1: c = 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
      2: c = CHAR_SPACE;
      default: begin
        c = 8'($urandom_range(1, 255));
        if (c == CHAR_TAB) c = 8'hFF;
      end
    endcase
    return c;
  endfunction

  function automatic void add_random_token(input int len);
    repeat (len) frame_bytes.push_back(random_text_char());
  endfunction

  // Closes the staged frame with a checksum token and sends it.
  task automatic finish_checked(input longint unsigned skew);
    longint unsigned claim;
    claim = 64'(frame_sum()) + skew;
    add_text({"\tC ", $sformatf("%0d", claim)});
    send_frame();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_frame();
  endtask

  task automatic build_random_frame();
    int              nfields;
    longint unsigned claim;
    string           type_name;
    // A fifth of the frames are plain noise with stray tabs.
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 24)) begin
        if ($urandom_range(4) == 0) frame_bytes.push_back(CHAR_TAB);
        else frame_bytes.push_back(random_text_char());
      end
      return;
    end
    case ($urandom_range(9))
      0, 1, 2: type_name = "PING";
      3, 4, 5: type_name = "POS";
      6:       type_name = "PINGS";
      7:       type_name = "PO";
      8:       type_name = "PONG";
      default: type_name = "";
    endcase
    if ($urandom_range(9) == 0) frame_bytes.push_back(CHAR_TAB);
    if (type_name.len() > 0) add_text(type_name);
    else add_random_token($urandom_range(1, 9));
    nfields = $urandom_range(0, 6);
    repeat (nfields) begin
      frame_bytes.push_back(CHAR_TAB);
      if ($urandom_range(7) == 0) frame_bytes.push_back(CHAR_TAB);
      add_random_token($urandom_range(1, 4));
    end
    claim = 64'(frame_sum());
    case ($urandom_range(9))
      0: claim = claim + 64'(65536) * $urandom_range(1, 999999);
      1: claim = $urandom_range(65535);
      default: ;
    endcase
    frame_bytes.push_back(CHAR_TAB);
    repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(8'h41, 8'h5a)));
    frame_bytes.push_back(CHAR_SPACE);
    add_text($sformatf("%0d", claim));
    if ($urandom_range(9) == 0) add_random_token($urandom_range(1, 3));
    if ($urandom_range(14) == 0) frame_bytes.push_back(CHAR_TAB);
    if ($urandom_range(9) == 0)
      frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom_range(1, 255));
  endtask

  task automatic test_directed();
    add_text("PING");                       finish_checked(0);
    add_text("POS\tx=1\ty=2");              finish_checked(0);
    add_text("PONG\tabc");                  finish_checked(0);
    add_text("PINGPONG");                   finish_checked(0);
    add_text("PIN");                        finish_checked(0);
    add_text("POSE\t1");                    finish_checked(0);
    add_text("PING\tdata");                 finish_checked(1);
    add_text("POS");                        finish_checked(64'(65536) * 7);
    add_text("\t\tPOS\t\ta\t");             finish_checked(0);
    add_text("PING\ta\tb\tc\td\te");        finish_checked(0);
    // One token too many: the checksum token is never captured.
    add_text("PING\ta\tb\tc\td\te\tf");     finish_checked(0);
    add_text("POS\t\377\200\001 \177");     finish_checked(0);
    send_text("PING\tC 12a3");
    send_text("PING\tC x");
    send_text("PING\tCX");
    send_text("PING\tC ");
    send_text("PING");
    send_text("Q");
    send_text("PING\tC 1\t");
    send_text("PING\tABCDEFGHIJKLM 12");
    send_text("PING\tABCDEFGHIJKLMNO 5");
    // An over-long line: the tail is summed but never tokenised.
    add_text("POS\tC 7");
    repeat (260) frame_bytes.push_back(8'h7a);
    frame_bytes.push_back(CHAR_TAB);
    frame_bytes.push_back(8'h71);
    send_frame();
    wait_for_results();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct);
    int bytes_sent;
    int frames_sent;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    bytes_sent    = 0;
    frames_sent   = 0;
    while (bytes_sent < 30 || frames_sent < 3) begin
      build_random_frame();
      bytes_sent += frame_bytes.size();
      frames_sent++;
      send_frame();
    end
    wait_for_results();
  endtask

  // The receiver stops for a long stretch so that results pile up and the
  // input is stalled; the sender then waits for everything to drain.
  task automatic test_back_pressure();
    send_idle_pct   = 0;
    hold_off_cycles = 150;
    repeat (3) begin
      add_text("PING\tfill");
      finish_checked(0);
    end
    wait_for_results();
  endtask

  initial begin
    clear_frame_state();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(32, 47);
    test_random(47, 32);
    test_random(0, 0);
    test_back_pressure();
    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[tab_message_frame_checker.f]
+incdir+sv
sv/tmfc_pkg.sv
sv/tmfc_in_stage.sv
sv/tmfc_parser.sv
sv/tmfc_result.sv
sv/tab_message_frame_checker.sv
sv/tmfc_checker.sv
test/tab_message_frame_checker_test.sv
